@@ rtl/console_line_editor_assert.svh @@
// ----------------------------------------------------------------------------
// Console line editor assertion macros
// Shorthand for the concurrent checks on the line editor ports.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// Console line editor package
// Shared widths, character codes, result channel codes and interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

   localparam int CNT_W      = 6;
   localparam int BYTE_W     = 8;
   localparam int MODE_W     = 2;
   localparam int CHAN_W     = 2;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Result channels
   localparam logic [CHAN_W-1:0] CH_ECHO = 2'd0;
   localparam logic [CHAN_W-1:0] CH_LINE = 2'd1;
   localparam logic [CHAN_W-1:0] CH_END  = 2'd2;

   // Editing modes; any code with the upper bit set is plain mode.
   localparam logic [MODE_W-1:0] MODE_EDIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ECHO = 2'd1;

   // Register indexes, taken from address bit 2
   localparam logic REG_MAX_LENGTH = 1'b0;
   localparam logic REG_EDIT_MODE  = 1'b1;

   localparam logic [CNT_W-1:0] MAX_LENGTH_RESET = 6'd32;

   // Character codes
   localparam logic [BYTE_W-1:0] CHR_BEL   = 8'h07;
   localparam logic [BYTE_W-1:0] CHR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;

   typedef struct packed {
      logic [CNT_W-1:0]  max_length;
      logic [MODE_W-1:0] edit_mode;
   } cle_cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [BYTE_W-1:0] out_byte;
      logic [CNT_W-1:0]  line_length;
      logic              last;
   } cle_rsp_type;

endpackage

`default_nettype wire

@@ rtl/cle_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                           wdata,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// Console line editor sequencer
// Classifies each request, updates the line store and count, and steps the
// echo bytes, line characters and end marker into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ctrl
   import cle_pkg::*;
#(
   parameter int MAX_CHARS = 32
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire cle_cfg_type                                    cfg,
   input  wire logic                                           req_valid,
   output logic                                                req_ready,
   input  wire logic [BYTE_W-1:0]                              req_rx_char,
   output logic                                                rsp_valid,
   input  wire logic                                           rsp_ready,
   output cle_rsp_type                                         rsp,
   output logic                                                ram_we,
   output logic                                                ram_re,
   output logic [((MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1)-1:0] ram_addr,
   output logic [BYTE_W-1:0]                                   ram_wdata,
   input  wire logic [BYTE_W-1:0]                              ram_rdata
);

   localparam int               AddrW     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam logic [CNT_W-1:0] MaxCharsC = CNT_W'(MAX_CHARS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_FLUSH,
      ST_EMIT,
      ST_END
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] echo_ff [3];
   logic [BYTE_W-1:0] echo_in [3];
   logic [1:0]        num_ff, num_in;
   logic [1:0]        eidx_ff, eidx_in;
   logic              flush_ff, flush_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cle_rsp_type       rsp_ff, rsp_in;

   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  next_idx;
   logic              full;
   logic              is_erase;
   logic              is_eol;
   logic              plain;
   logic              slot_free;

   assign limit     = (cfg.max_length < MaxCharsC) ? cfg.max_length : MaxCharsC;
   assign full      = (count_ff >= limit);
   assign is_erase  = (req_rx_char == CHR_BS) || (req_rx_char == CHR_DEL);
   assign is_eol    = (req_rx_char == CHR_LF) || (req_rx_char == CHR_CR);
   assign plain     = cfg.edit_mode[1];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign next_idx  = idx_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      echo_in      = echo_ff;
      num_in       = num_ff;
      eidx_in      = eidx_ff;
      flush_in     = flush_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = count_ff[AddrW-1:0];
      ram_wdata    = req_rx_char;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               eidx_in  = 2'd0;
               flush_in = 1'b0;
               num_in   = 2'd1;
               echo_in  = '{req_rx_char, req_rx_char, req_rx_char};
               if (plain) begin
                  // Plain mode echoes first; the ending character is dropped.
                  if (is_eol || full) begin
                     flush_in = 1'b1;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (is_erase) begin
                  if (cfg.edit_mode == MODE_ECHO) begin
                     echo_in[0] = CHR_BEL;
                  end else if (count_ff != '0) begin
                     echo_in  = '{CHR_BS, CHR_SPACE, CHR_BS};
                     num_in   = 2'd3;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     num_in = 2'd0;
                  end
               end else if (is_eol) begin
                  echo_in[0] = CHR_CR;
                  echo_in[1] = CHR_LF;
                  num_in     = 2'd2;
                  flush_in   = 1'b1;
               end else if (!full) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  echo_in[0] = CHR_BEL;
               end
               // In edit mode, erasing on an empty line gives no result at all.
               state_in = (num_in == 2'd0) ? ST_IDLE : ST_ECHO;
            end
         end

         ST_ECHO: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.channel     = CH_ECHO;
               rsp_in.out_byte    = echo_ff[eidx_ff];
               rsp_in.line_length = '0;
               rsp_in.last        = (eidx_ff == num_ff - 2'd1) && !flush_ff;
               eidx_in            = eidx_ff + 2'd1;
               if (eidx_ff == num_ff - 2'd1) begin
                  state_in = flush_ff ? ST_FLUSH : ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (count_ff == '0) begin
               state_in = ST_END;
            end else begin
               ram_re   = 1'b1;
               ram_addr = '0;
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            // The read for the next character is issued as this one leaves,
            // so the store delivers one character per cycle when unstalled.
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.channel     = CH_LINE;
               rsp_in.out_byte    = ram_rdata;
               rsp_in.line_length = '0;
               rsp_in.last        = 1'b0;
               if (next_idx < count_ff) begin
                  ram_re   = 1'b1;
                  ram_addr = next_idx[AddrW-1:0];
                  idx_in   = next_idx;
               end else begin
                  state_in = ST_END;
               end
            end
         end

         ST_END: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.channel     = CH_END;
               rsp_in.out_byte    = CHR_NUL;
               rsp_in.line_length = count_ff;
               rsp_in.last        = 1'b1;
               count_in           = '0;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_ff       <= '0;
         eidx_ff      <= '0;
         flush_ff     <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_ff       <= num_in;
         eidx_ff      <= eidx_in;
         flush_ff     <= flush_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      echo_ff <= echo_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/console_line_editor.sv @@
// ----------------------------------------------------------------------------
// Console line editor
// Terminal line editor with erase, bell and echo handling over a line store.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Moves
//   -------   ---------------------------   --------------------------------
//   request   req_valid/req_ready/req_*     one received character
//   result    rsp_valid/rsp_ready/rsp_*     echo byte, line character, end
//   config    psel/penable/pwrite/paddr/..  max_length (0x0), edit_mode (0x4)
//
// A character is taken while the editor is idle, and each result it causes is
// loaded into the result register in turn, holding while the result side stalls.
// Ending a line of N characters gives its echoes, then starts a read of the
// line store, then gives the N line characters and the end marker; the single
// port of the line store paces the line characters. The next request is taken
// once the last result has been loaded into the result register, even while it
// waits to be taken. Reset clears the count and the mode and sets the limit to
// 32; the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor
   import cle_pkg::*;
#(
   parameter int MAX_CHARS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_rx_char,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CHAN_W-1:0]          rsp_channel,
   output logic [BYTE_W-1:0]          rsp_out_byte,
   output logic [CNT_W-1:0]           rsp_line_length,
   output logic                       rsp_last,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int AddrW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

   logic [CNT_W-1:0]  max_length_ff, max_length_in;
   logic [MODE_W-1:0] edit_mode_ff, edit_mode_in;
   logic              wr_en;
   cle_cfg_type       cfg;
   cle_rsp_type       rsp;
   logic              ram_we;
   logic              ram_re;
   logic [AddrW-1:0]  ram_addr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      max_length_in = max_length_ff;
      edit_mode_in  = edit_mode_ff;
      if (wr_en) begin
         if (paddr[2] == REG_EDIT_MODE) begin
            edit_mode_in = pwdata[MODE_W-1:0];
         end else begin
            max_length_in = pwdata[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         edit_mode_ff  <= MODE_EDIT;
      end else begin
         max_length_ff <= max_length_in;
         edit_mode_ff  <= edit_mode_in;
      end
   end

   assign prdata = (paddr[2] == REG_EDIT_MODE) ? APB_DATA_W'(edit_mode_ff)
                                                : APB_DATA_W'(max_length_ff);

   assign cfg.max_length = max_length_ff;
   assign cfg.edit_mode  = edit_mode_ff;

   cle_ctrl #(
      .MAX_CHARS (MAX_CHARS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_char (req_rx_char),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .ram_we      (ram_we),
      .ram_re      (ram_re),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .ram_rdata   (ram_rdata)
   );

   cle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_CHARS)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_channel     = rsp.channel;
   assign rsp_out_byte    = rsp.out_byte;
   assign rsp_line_length = rsp.line_length;
   assign rsp_last        = rsp.last;

endmodule

`default_nettype wire

@@ rtl/console_line_editor_chk.sv @@
// ----------------------------------------------------------------------------
// Console line editor port checker
// Concurrent checks on the request and result ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "console_line_editor_assert.svh"

module console_line_editor_chk
   import cle_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CHAN_W-1:0] rsp_channel,
   input wire logic [BYTE_W-1:0] rsp_out_byte,
   input wire logic [CNT_W-1:0]  rsp_line_length,
   input wire logic              rsp_last
);

   // A stalled result must hold still until it is taken.
   `CLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel) && $stable(rsp_out_byte) && $stable(rsp_line_length) && $stable(rsp_last), "result changed while stalled")

   // The end marker carries no byte and closes the request.
   `CLE_ASSERT_SAME(a_end_form, clock, reset, rsp_valid && rsp_channel == CH_END, rsp_out_byte == CHR_NUL && rsp_last, "malformed end of line result")

   // A line character is always followed at once by another result.
   `CLE_ASSERT_NEXT(a_line_cont, clock, reset, rsp_valid && rsp_ready && rsp_channel == CH_LINE, rsp_valid, "gap after a line character")

   // While a request still has results to come, no new request is taken.
   `CLE_ASSERT_SAME(a_busy_block, clock, reset, rsp_valid && !rsp_last, !req_ready, "request taken before the previous one finished")

endmodule

bind console_line_editor console_line_editor_chk u_chk (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console line editor testbench
// Sends received characters through the request channel and checks every
// echo byte, line character and end-of-line marker against an in-bench model
// of the editor, across edit, echo-only and plain modes and several limits.
// ----------------------------------------------------------------------------
module tb_top;
   import cle_pkg::*;

   localparam int LINE_CAP = 32;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PLAIN_ALT = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_W-1:0] req_rx_char = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_channel;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic [CNT_W-1:0] rsp_line_length;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [APB_ADDR_W-1:0] paddr = '0;
   logic [APB_DATA_W-1:0] pwdata = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic pready;

   // Shadow copy of the editor state and its registers
   logic [BYTE_W-1:0] shadow_line [0:LINE_CAP-1];
   int unsigned shadow_count = 0;
   logic [CNT_W-1:0] shadow_max_length = MAX_LENGTH_RESET;
   logic [MODE_W-1:0] shadow_mode = MODE_EDIT;

   cle_rsp_type editor_results_due[$];
   cle_rsp_type oldest_due;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;

   console_line_editor #(.MAX_CHARS(LINE_CAP)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_char(req_rx_char),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_channel(rsp_channel),
      .rsp_out_byte(rsp_out_byte),
      .rsp_line_length(rsp_line_length),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The result side rotates through free flow, light stalls, heavy stalls
   // and a fixed periodic stall.
   always @(posedge clock) begin
      case ((cycle_count / 400) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 2) == 0);
         default: rsp_ready <= ((cycle_count % 5) > 1);
      endcase
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (editor_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result channel %0d byte %02h",
                                      rsp_channel, rsp_out_byte));
         end else begin
            oldest_due = editor_results_due.pop_front();
            if (rsp_channel !== oldest_due.channel)
               report_mismatch($sformatf("channel %0d, expected %0d",
                                         rsp_channel, oldest_due.channel));
            if (rsp_out_byte !== oldest_due.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, oldest_due.out_byte));
            if (rsp_line_length !== oldest_due.line_length)
               report_mismatch($sformatf("line_length %0d, expected %0d",
                                         rsp_line_length, oldest_due.line_length));
            if (rsp_last !== oldest_due.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_last, oldest_due.last));
         end
      end
   end

   function automatic void owe_result(input logic [CHAN_W-1:0] chan,
                                      input logic [BYTE_W-1:0] data,
                                      input logic [CNT_W-1:0] len);
      cle_rsp_type r;
      r.channel = chan;
      r.out_byte = data;
      r.line_length = len;
      r.last = 1'b0;
      editor_results_due.push_back(r);
   endfunction

   function automatic void owe_finished_line();
      for (int i = 0; i < shadow_count; i++)
         owe_result(CH_LINE, shadow_line[i], '0);
      owe_result(CH_END, CHR_NUL, CNT_W'(shadow_count));
      shadow_count = 0;
   endfunction

   // Works out every result that one received character causes.
   function automatic void predict_keystroke(input logic [BYTE_W-1:0] c);
      int unsigned limit_now;
      int unsigned owed_before;
      bit erase_c;
      bit eol_c;
      bit full_c;
      owed_before = editor_results_due.size();
      limit_now = (shadow_max_length < LINE_CAP) ? shadow_max_length : LINE_CAP;
      erase_c = (c == CHR_BS) || (c == CHR_DEL);
      eol_c = (c == CHR_CR) || (c == CHR_LF);
      full_c = (shadow_count >= limit_now);
      if (shadow_mode[1]) begin
         owe_result(CH_ECHO, c, '0);
         if (eol_c || full_c) begin
            owe_finished_line();
         end else begin
            shadow_line[shadow_count] = c;
            shadow_count++;
         end
      end else if (erase_c) begin
         if (shadow_mode == MODE_ECHO) begin
            owe_result(CH_ECHO, CHR_BEL, '0);
         end else if (shadow_count > 0) begin
            owe_result(CH_ECHO, CHR_BS, '0);
            owe_result(CH_ECHO, CHR_SPACE, '0);
            owe_result(CH_ECHO, CHR_BS, '0);
            shadow_count--;
         end
      end else if (eol_c) begin
         owe_result(CH_ECHO, CHR_CR, '0);
         owe_result(CH_ECHO, CHR_LF, '0);
         owe_finished_line();
      end else if (!full_c) begin
         shadow_line[shadow_count] = c;
         shadow_count++;
         owe_result(CH_ECHO, c, '0);
      end else begin
         owe_result(CH_ECHO, CHR_BEL, '0);
      end
      if (editor_results_due.size() > owed_before)
         editor_results_due[editor_results_due.size() - 1].last = 1'b1;
   endfunction

   // Called right after a rising edge; returns right after the edge that
   // took the request, or after the idle gap that follows a burst.
   task automatic send_char(input logic [BYTE_W-1:0] c);
      int unsigned gap;
      req_valid <= 1'b1;
      req_rx_char <= c;
      do @(posedge clock); while (!req_ready);
      predict_keystroke(c);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                 : $urandom_range(0, 8);
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // An erase on an empty line in edit mode gives no result, so the bench waits
   // an extra settling time after the last result before the editor counts as idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (editor_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
      logic [APB_DATA_W-1:0] field_mask;
      wait_idle();
      field_mask = (reg_idx == REG_MAX_LENGTH) ? APB_DATA_W'((1 << CNT_W) - 1)
                                               : APB_DATA_W'((1 << MODE_W) - 1);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (reg_idx == REG_MAX_LENGTH)
         shadow_max_length = value[CNT_W-1:0];
      else
         shadow_mode = value[MODE_W-1:0];
      // Read the register back.
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((prdata & field_mask) !== (value & field_mask))
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   reg_idx, prdata & field_mask, value & field_mask));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Runs on the reset settings: full edit mode with a 32 character limit.
   task automatic test_edit_erase();
      send_char(CHR_BS);
      send_char(CHR_DEL);
      send_char("a");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h80);
      send_char(CHR_DEL);
      send_char(CHR_BS);
      send_char("b");
      send_char(CHR_CR);
      send_char(CHR_LF);
   endtask

   task automatic test_echo_bell();
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_ECHO));
      send_char("x");
      send_char(CHR_BS);
      send_char(CHR_DEL);
      send_char(CHR_LF);
   endtask

   task automatic test_plain_echo();
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_PLAIN));
      write_csr(REG_MAX_LENGTH, 3);
      send_char("p");
      send_char(CHR_BS);
      send_char("q");
      send_char("r");
      send_char(CHR_CR);
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_PLAIN_ALT));
      send_char(CHR_DEL);
      send_char(CHR_LF);
   endtask

   task automatic test_line_limits();
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_EDIT));
      write_csr(REG_MAX_LENGTH, 1);
      send_char("a");
      send_char("b");
      send_char(CHR_CR);
      // With a zero limit the line is always full.
      write_csr(REG_MAX_LENGTH, 0);
      send_char("c");
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_PLAIN));
      send_char("d");
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_EDIT));
      write_csr(REG_MAX_LENGTH, 63);
      send_char("f");
      send_char(CHR_CR);
   endtask

   task automatic test_midline_changes();
      write_csr(REG_MAX_LENGTH, 32);
      send_char("g");
      send_char("h");
      send_char("i");
      // The stored line stays when the limit drops below the count.
      write_csr(REG_MAX_LENGTH, 2);
      send_char("k");
      send_char(CHR_DEL);
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_PLAIN));
      send_char("l");
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_EDIT));
      write_csr(REG_MAX_LENGTH, 32);
      send_char("m");
      write_csr(REG_EDIT_MODE, APB_DATA_W'(MODE_PLAIN));
      send_char("n");
      send_char(CHR_CR);
   endtask

   // Mostly typed lines ended by CR or LF, with erases and arbitrary bytes
   // mixed in; now and then a line runs past the limit.
   task automatic test_random_lines();
      logic [MODE_W-1:0] mode_pick;
      logic [CNT_W-1:0] limit_pick;
      logic [BYTE_W-1:0] c;
      int unsigned sent;
      int unsigned line_len;
      int unsigned pick;
      for (int ph = 0; ph < 6; ph++) begin
         mode_pick = (ph < 4) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0: limit_pick = CNT_W'(0);
            1, 2: limit_pick = CNT_W'(32);
            3: limit_pick = CNT_W'(63);
            default: limit_pick = CNT_W'($urandom_range(1, 8));
         endcase
         write_csr(REG_EDIT_MODE, APB_DATA_W'(mode_pick));
         write_csr(REG_MAX_LENGTH, APB_DATA_W'(limit_pick));
         sent = 0;
         while (sent < 25) begin
            line_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 34)
                                                   : $urandom_range(0, 7);
            for (int k = 0; k < line_len; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 84)
                  c = BYTE_W'($urandom_range(8'h20, 8'h7E));
               else if (pick < 92)
                  c = $urandom_range(0, 1) ? CHR_BS : CHR_DEL;
               else
                  c = BYTE_W'($urandom_range(0, 255));
               send_char(c);
               sent++;
            end
            send_char($urandom_range(0, 1) ? CHR_CR : CHR_LF);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edit_erase();
      test_echo_bell();
      test_plain_echo();
      test_line_limits();
      test_midline_changes();
      test_random_lines();
      wait_idle();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
